// ----- rtl/sha256_pkg.sv -----
`default_nettype none
package sha256_pkg;

  typedef struct packed {
    logic buf_wr;      // write byte into block buffer
    logic [7:0] buf_data;
    logic [5:0] buf_addr;
    logic init;        // reset chaining state
    logic load_w;      // start a block: copy chain into working vars
    logic fold;        // add working vars into chain
  } sha_cmd_t;

  typedef struct packed {
    logic rnd_done;
  } sha_sts_t;

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sha256_dp.sv -----
`default_nettype none
module sha256_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sha256_pkg::sha_cmd_t cmd,
  output sha256_pkg::sha_sts_t      sts,
  output logic [255:0]              digest
);
  import sha256_pkg::*;

  logic [7:0]  mem [64];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];   // message schedule window
  logic [6:0]  rcnt_r;     // round index 0..63
  logic [3:0]  ld_r;
  logic [31:0] rd_word;
  logic [7:0]  rd_b;
  logic [5:0]  rd_addr;
  logic        loading_r;
  logic [1:0]  bsel_r;
  logic [31:0] acc_r;
  logic        run_r;
  logic [31:0] t1, t2, s0, s1, wn, e, a;

  // bytes are read one a cycle: all 64 bytes are loaded, then 64 rounds run
  always_ff @(posedge clk) begin
    if (cmd.buf_wr) mem[cmd.buf_addr] <= cmd.buf_data;
    rd_b <= mem[rd_addr];
  end

  assign rd_addr = {ld_r, bsel_r};
  assign rd_word = {acc_r[23:0], rd_b};

  assign e  = v_r[4];
  assign a  = v_r[0];
  assign s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wn = s1 + w_r[9] + s0 + w_r[0];
  assign t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
              ((e & v_r[5]) ^ (~e & v_r[6])) + K[rcnt_r[5:0]] + w_r[0];
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
              ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  logic rd_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r <= 1'b0;
      run_r <= 1'b0;
      rd_v_r <= 1'b0;
      ld_r <= '0;
      bsel_r <= '0;
      rcnt_r <= '0;
    end else begin
      rd_v_r <= loading_r;
      if (cmd.load_w) begin
        loading_r <= 1'b1;
        ld_r <= '0;
        bsel_r <= '0;
        rcnt_r <= '0;
      end else if (loading_r) begin
        bsel_r <= bsel_r + 2'd1;
        if (bsel_r == 2'd3) begin
          ld_r <= ld_r + 4'd1;
          if (ld_r == 4'd15) loading_r <= 1'b0;
        end
      end
      if (rd_v_r && !loading_r) run_r <= 1'b1;
      if (run_r) begin
        rcnt_r <= rcnt_r + 7'd1;
        if (rcnt_r == 7'd63) run_r <= 1'b0;
      end
    end
  end

  logic [1:0] wcnt_r;
  always_ff @(posedge clk) begin
    if (cmd.load_w) wcnt_r <= '0;
    if (rd_v_r) begin
      acc_r <= rd_word;
      if (wcnt_r == 2'd3) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= rd_word;
      end
      wcnt_r <= wcnt_r + 2'd1;
    end
    if (cmd.load_w) for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    if (run_r) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= e; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= a; v_r[0] <= t1 + t2;
    end
    if (!rst_n || cmd.init) for (int i = 0; i < 8; i++) h_r[i] <= H0[i];
    else if (cmd.fold) for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
  end

  assign sts.rnd_done = run_r && rcnt_r == 7'd63;
  assign digest = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4], h_r[5], h_r[6], h_r[7]};
endmodule
`default_nettype wire

// ----- rtl/sha256_ctrl.sv -----
`default_nettype none
module sha256_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_fire,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_present,
  input  wire logic                 in_last,
  output logic                      in_ready,
  output logic                      res_load,
  input  wire logic                 res_free,
  output sha256_pkg::sha_cmd_t      cmd,
  input  wire sha256_pkg::sha_sts_t sts
);
  import sha256_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_RUN  = 6'b000010, S_FOLD = 6'b000100,
    S_PAD  = 6'b001000, S_LEN  = 6'b010000, S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic        fin_r, fin_nxt;   // finishing message
  logic        padded_r, padded_nxt; // 0x80 already written
  logic        lenblk_r, lenblk_nxt; // final block being hashed

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    bits_nxt = bits_r;
    fin_nxt = fin_r;
    padded_nxt = padded_r;
    lenblk_nxt = lenblk_r;
    cmd = '0;
    res_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_present) begin
            cmd.buf_wr = 1'b1;
            cmd.buf_addr = fill_r;
            cmd.buf_data = in_byte;
            fill_nxt = fill_r + 6'd1;
            bits_nxt = bits_r + 64'd8;
          end
          fin_nxt = in_last;
          if (in_present && fill_r == 6'd63) begin
            cmd.load_w = 1'b1;
            state_nxt = S_RUN;
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_RUN: if (sts.rnd_done) state_nxt = S_FOLD;
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (lenblk_r) state_nxt = S_OUT;
        else if (fin_r) state_nxt = S_PAD;
        else state_nxt = S_IDLE;
      end
      S_PAD: begin
        // 0x80 once, then zeros, one byte a cycle
        cmd.buf_wr = 1'b1;
        cmd.buf_addr = fill_r;
        cmd.buf_data = padded_r ? 8'h00 : PAD_BYTE;
        padded_nxt = 1'b1;
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          cmd.load_w = 1'b1;
          state_nxt = S_RUN;
        end else if (fill_r == LEN_POS - 6'd1) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.buf_wr = 1'b1;
        cmd.buf_addr = fill_r;
        cmd.buf_data = bits_r[8*(7-fill_r[2:0]) +: 8];
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          cmd.load_w = 1'b1;
          lenblk_nxt = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_OUT: begin
        if (res_free) begin
          res_load = 1'b1;
          cmd.init = 1'b1;
          fill_nxt = '0;
          bits_nxt = '0;
          fin_nxt = 1'b0;
          padded_nxt = 1'b0;
          lenblk_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      bits_r <= '0;
      fin_r <= 1'b0;
      padded_r <= 1'b0;
      lenblk_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      bits_r <= bits_nxt;
      fin_r <= fin_nxt;
      padded_r <= padded_nxt;
      lenblk_r <= lenblk_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sha256_stream_hasher_top.sv -----
// sha-256 over a byte stream, one byte per word. a word with tlast ends the
// message; padding and length blocks follow and the 256-bit digest is shown on
// the out channel. input is taken only while idle; a byte that fills a block
// holds the input while its bytes are loaded as words, the rounds run and the
// chain is folded. finishing writes the padding and the length into one or two
// more blocks, each compressed in turn, then waits until the out port is free.
`default_nettype none
module sha256_stream_hasher_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // data_byte
  input  wire logic         in_tuser,   // byte_present
  input  wire logic         in_tlast,   // last_item
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [255:0]      out_tdata   // digest_part0..3 from low bits up
);
  import sha256_pkg::*;

  sha_cmd_t cmd;
  sha_sts_t sts;
  logic [255:0] digest;
  logic res_load, in_fire, res_free;

  assign in_fire = in_tvalid && in_tready;
  assign res_free = !out_tvalid || out_tready;

  sha256_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_byte(in_tdata), .in_present(in_tuser),
    .in_last(in_tlast), .in_ready(in_tready), .res_load, .res_free,
    .cmd, .sts
  );

  sha256_dp u_dp (.clk, .rst_n, .cmd, .sts, .digest);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (res_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
    if (res_load) out_tdata <= {digest[63:0], digest[127:64], digest[191:128],
                                digest[255:192]};
  end
endmodule
`default_nettype wire

// ----- rtl/sha256_checker.sv -----
`default_nettype none
module sha256_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         in_tlast,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [255:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out held");
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready) else $error("busy after last");
  a_no_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready)) else $error("digest w/o finish");
endmodule

bind sha256_stream_hasher_top sha256_checker u_chk (.*);
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import sha256_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;    // data_byte
  logic         in_tuser = 1'b0;  // byte_present
  logic         in_tlast = 1'b0;  // last_item
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [255:0] out_tdata;        // digest_part0..3 from low bits up

  sha256_stream_hasher_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_item;
  } msg_word_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [31:0]  hash_h [8];
  logic [7:0]   blk [64];
  int           blk_fill;
  logic [63:0]  bit_len;

  msg_word_t    word_queue [$];
  logic [255:0] digest_queue [$];
  int           errors = 0;
  int           send_idle = 17;
  int           recv_idle = 71;
  bit           stim_done = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < 8; i++) hash_h[i] = IV[i];
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    blk_fill = 0;
    bit_len = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3];
    e = hash_h[4]; f = hash_h[5]; g = hash_h[6]; h = hash_h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
    hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
  endtask

  task automatic absorb_word(msg_word_t wd);
    logic [255:0] dg;
    if (wd.byte_present) begin
      blk[blk_fill] = wd.data_byte;
      bit_len += 64'd8;
      blk_fill++;
      if (blk_fill == 64) begin
        compress_block();
        blk_fill = 0;
      end
    end
    if (wd.last_item) begin
      blk[blk_fill] = 8'h80;
      blk_fill++;
      if (blk_fill > 56) begin
        while (blk_fill < 64) begin blk[blk_fill] = 8'h00; blk_fill++; end
        compress_block();
        blk_fill = 0;
      end
      while (blk_fill < 56) begin blk[blk_fill] = 8'h00; blk_fill++; end
      for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
      compress_block();
      // part0 in low bits, each part is words 2i,2i+1 big-endian
      for (int i = 0; i < 4; i++) dg[64*i +: 64] = {hash_h[2*i], hash_h[2*i+1]};
      digest_queue.push_back(dg);
      hash_reset();
    end
  endtask

  task automatic report_mismatch(string what, logic [255:0] got, logic [255:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic push_word(logic [7:0] d, logic p, logic l);
    msg_word_t wd;
    wd.data_byte = d; wd.byte_present = p; wd.last_item = l;
    word_queue.push_back(wd);
  endtask

  task automatic push_message(int len);
    for (int i = 0; i < len; i++)
      push_word(8'($urandom), 1'b1, (i == len - 1) ? 1'b1 : 1'b0);
  endtask

  // driver
  always @(posedge clk) begin
    msg_word_t wd;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (word_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
          wd = word_queue.pop_front();
          absorb_word(wd);
          in_tvalid <= 1'b1;
          in_tdata <= wd.data_byte;
          in_tuser <= wd.byte_present;
          in_tlast <= wd.last_item;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected digest", out_tdata, '0);
      end else begin
        logic [255:0] want;
        want = digest_queue.pop_front();
        for (int i = 0; i < 4; i++)
          if (out_tdata[64*i +: 64] !== want[64*i +: 64])
            report_mismatch($sformatf("digest_part%0d", i),
                            256'(out_tdata[64*i +: 64]), 256'(want[64*i +: 64]));
      end
    end
  end

  task automatic run_phase(int n_items);
    int target;
    target = n_items;
    while (target > 0) begin
      int r, len;
      r = $urandom_range(99);
      if (r < 80) begin
        // mostly short messages, a few spanning several blocks
        if ($urandom_range(9) == 0) len = $urandom_range(200, 50);
        else len = $urandom_range(70, 1);
        push_message(len);
        target -= len;
      end else if (r < 90) begin
        len = $urandom_range(60);
        push_message(len);
        push_word(8'($urandom), 1'b0, 1'b0);
        push_word(8'($urandom), 1'b0, 1'b1);
        target -= len + 2;
      end else begin
        push_word(8'($urandom), 1'b0, $urandom_range(1));
        target -= 1;
      end
    end
    while (word_queue.size() > 0 || in_tvalid) @(posedge clk);
    while (digest_queue.size() > 0) @(posedge clk);
  endtask

  initial begin
    hash_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed: empty message, one-byte messages, words without a byte, tail lengths around the padding boundary
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hff, 1'b1, 1'b1);
    push_word(8'h00, 1'b1, 1'b1);
    push_word(8'h5a, 1'b0, 1'b0);
    push_word(8'ha5, 1'b1, 1'b0);
    push_word(8'h3c, 1'b0, 1'b1);
    push_message(55);
    push_message(56);
    push_message(63);
    push_message(64);
    push_message(65);
    for (int i = 0; i < 64; i++) push_word(8'($urandom), 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    run_phase(0);
    send_idle = 17; recv_idle = 71;
    run_phase(250);
    send_idle = 71; recv_idle = 17;
    run_phase(250);
    send_idle = 0; recv_idle = 0;
    run_phase(250);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("[sha256_stream_hasher_top] OK");
    else $display("[sha256_stream_hasher_top] ERROR");
    $finish;
  end

  initial begin
    #40ms;
    $display("[sha256_stream_hasher_top] ERROR");
    $finish;
  end

endmodule

// ----- sha256_stream_hasher_top.f -----
rtl/sha256_pkg.sv
rtl/sha256_dp.sv
rtl/sha256_ctrl.sv
rtl/sha256_stream_hasher_top.sv
rtl/sha256_checker.sv
sim/testbench.sv
